@@ design/iir_step_impulse_response_defines.svh @@
// assertion macros for the step and impulse response filter
`ifndef IIR_STEP_IMPULSE_RESPONSE_DEFINES_SVH
`define IIR_STEP_IMPULSE_RESPONSE_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define IIR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iir same-cycle check failed");

// next-cycle implication, checked on clk, off during reset
`define IIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iir next-cycle check failed");

`endif

@@ design/iir_sir_pkg.sv @@
// shared types and constants of the step and impulse response filter
`default_nettype none

package iir_sir_pkg;

    // request commands
    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_LOAD_B  = 2'd0;
    localparam cmd_code_t CMD_LOAD_A  = 2'd1;
    localparam cmd_code_t CMD_RESTART = 2'd2;
    localparam cmd_code_t CMD_SAMPLE  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_NUM_DEG  = 2'd0;
    localparam cfg_idx_t CFG_DEN_DEG  = 2'd1;
    localparam cfg_idx_t CFG_SRC_MODE = 2'd2;

    // field widths
    localparam int COEFF_IDX_W = 4;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 16;
    localparam int ACC_W       = 64;
    localparam int DIV_STEPS   = 32;
    localparam int DIVCNT_W    = 5;

    localparam logic [VALUE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    // controller to datapath
    typedef struct packed {
        logic load_b;
        logic load_a;
        logic restart;
        logic start;
        logic src_impulse;
        logic num_step;
        logic den_issue;
        logic den_acc;
        logic div_prep;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip_div;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/iir_sir_if.sv @@
// channel interfaces: request, response and configuration write
`default_nettype none

interface iir_req_if;
    logic                                    valid;
    logic                                    ready;
    iir_sir_pkg::cmd_code_t                  command;
    logic [iir_sir_pkg::COEFF_IDX_W-1:0]     coeff_index;
    logic signed [iir_sir_pkg::VALUE_W-1:0]  coeff_value;
    modport source (output valid, output command, output coeff_index, output coeff_value,
                    input ready);
    modport sink (input valid, input command, input coeff_index, input coeff_value,
                  output ready);
endinterface

interface iir_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [iir_sir_pkg::VALUE_W-1:0]  response_sample;
    logic [iir_sir_pkg::INDEX_W-1:0]         sample_index;
    logic                                    divide_error;
    logic                                    saturated;
    modport source (output valid, output response_sample, output sample_index,
                    output divide_error, output saturated, input ready);
    modport sink (input valid, input response_sample, input sample_index,
                  input divide_error, input saturated, output ready);
endinterface

interface iir_cfg_if;
    logic                                    valid;
    logic                                    ready;
    iir_sir_pkg::cfg_idx_t                   index;
    logic [iir_sir_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/iir_sir_ctrl.sv @@
// controller: sequencing of taps and division, configuration registers
`default_nettype none

module iir_sir_ctrl #(
    parameter int MAX_DEGREE = 15,
    parameter int IDX_W      = 4
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   req_valid,
    input  wire iir_sir_pkg::cmd_code_t           req_command,
    output logic                                  req_ready,
    input  wire                                   cfg_valid,
    input  wire iir_sir_pkg::cfg_idx_t            cfg_index,
    input  wire [iir_sir_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                  cfg_ready,
    input  wire iir_sir_pkg::dp_status_t          status,
    output iir_sir_pkg::dp_cmd_t                  cmd,
    output logic [IDX_W-1:0]                      tap
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NUM   = 3'd1;
    localparam logic [2:0] S_DEN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [IDX_W-1:0]                    tap_reg, tap_next;
    logic [iir_sir_pkg::DIVCNT_W-1:0]    divcnt_reg, divcnt_next;
    logic                                pend_reg, pend_next;
    logic [IDX_W-1:0]                    num_deg_reg, num_deg_next;
    logic [IDX_W-1:0]                    den_deg_reg, den_deg_next;
    logic                                src_reg, src_next;
    logic [IDX_W-1:0]                    deg_clamped;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign tap       = tap_reg;

    // degree clamp to the history depth
    assign deg_clamped = (32'(cfg_data) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(cfg_data);

    // configuration writes
    always_comb
    begin
        num_deg_next = num_deg_reg;
        den_deg_next = den_deg_reg;
        src_next     = src_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                iir_sir_pkg::CFG_NUM_DEG:  num_deg_next = deg_clamped;
                iir_sir_pkg::CFG_DEN_DEG:  den_deg_next = deg_clamped;
                iir_sir_pkg::CFG_SRC_MODE: src_next     = cfg_data[0];
                default:                   src_next     = src_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        divcnt_next = divcnt_reg;
        pend_next   = (state_reg == S_DEN);
        cmd             = '0;
        cmd.src_impulse = src_reg;
        cmd.den_acc     = pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_command)
                        iir_sir_pkg::CMD_LOAD_B:  cmd.load_b  = 1'b1;
                        iir_sir_pkg::CMD_LOAD_A:  cmd.load_a  = 1'b1;
                        iir_sir_pkg::CMD_RESTART: cmd.restart = 1'b1;
                        iir_sir_pkg::CMD_SAMPLE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_NUM;
                            tap_next   = '0;
                        end
                        default: cmd.restart = 1'b0;
                    endcase
                end
            end
            S_NUM:
            begin
                cmd.num_step = 1'b1;
                if (tap_reg == num_deg_reg)
                begin
                    tap_next   = IDX_W'(1);
                    state_next = (den_deg_reg == '0) ? S_PREP : S_DEN;
                end
                else
                begin
                    tap_next = tap_reg + IDX_W'(1);
                end
            end
            S_DEN:
            begin
                cmd.den_issue = 1'b1;
                if (tap_reg == den_deg_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.div_prep = 1'b1;
                divcnt_next  = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.skip_div)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    divcnt_next  = divcnt_reg + 1'b1;
                    if (divcnt_reg == iir_sir_pkg::DIVCNT_W'(iir_sir_pkg::DIV_STEPS - 1))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            divcnt_reg  <= '0;
            pend_reg    <= 1'b0;
            num_deg_reg <= '0;
            den_deg_reg <= '0;
            src_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            divcnt_reg  <= divcnt_next;
            pend_reg    <= pend_next;
            num_deg_reg <= num_deg_next;
            den_deg_reg <= den_deg_next;
            src_reg     <= src_next;
        end
    end

endmodule

`default_nettype wire

@@ design/iir_sir_dp.sv @@
// datapath: coefficients, histories, multiply-accumulate, divider, output word
`default_nettype none

module iir_sir_dp #(
    parameter int MAX_DEGREE  = 15,
    parameter int COEFF_WIDTH = 32,
    parameter int IDX_W       = 4
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire iir_sir_pkg::dp_cmd_t                    cmd,
    input  wire [IDX_W-1:0]                              tap,
    output iir_sir_pkg::dp_status_t                      status,
    input  wire [iir_sir_pkg::COEFF_IDX_W-1:0]           coeff_index,
    input  wire signed [iir_sir_pkg::VALUE_W-1:0]        coeff_value,
    input  wire                                          out_ready,
    output logic                                         out_valid,
    output logic signed [iir_sir_pkg::VALUE_W-1:0]       out_sample,
    output logic [iir_sir_pkg::INDEX_W-1:0]              out_index,
    output logic                                         out_err,
    output logic                                         out_sat
);

    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int COEFF_BITS = (COEFF_WIDTH < 32) ? COEFF_WIDTH : 32;
    localparam int VW         = iir_sir_pkg::VALUE_W;
    localparam int AW         = iir_sir_pkg::ACC_W;

    logic signed [VW-1:0]   b_mem [DEPTH];
    logic signed [VW-1:0]   a_mem [DEPTH];
    logic                   xh_reg [DEPTH];
    logic signed [VW-1:0]   yh_reg [DEPTH];
    logic [iir_sir_pkg::INDEX_W-1:0] count_reg;
    logic                   first_reg;

    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   prod_reg;
    logic                   err_reg, ovf_reg, neg_reg, accneg_reg;
    logic [VW-1:0]          rem_reg, nl_reg, quo_reg, dmag_reg;

    logic signed [VW-1:0]   coeff_ext;
    logic                   idx_ok;
    logic [IDX_W-1:0]       load_idx;
    logic                   x_new;
    logic signed [AW-1:0]   b_term, d_term;
    logic [AW-1:0]          acc_mag;
    logic [AW+7:0]          n_wide;
    logic signed [VW-1:0]   a0;
    logic [VW-1:0]          a0_mag;
    logic [VW:0]            r_shift;
    logic                   r_ge;
    logic signed [VW-1:0]   y_val;
    logic                   y_sat;

    assign coeff_ext = VW'($signed(coeff_value[COEFF_BITS-1:0]));
    assign idx_ok    = (32'(coeff_index) <= MAX_DEGREE);
    assign load_idx  = IDX_W'(coeff_index);
    assign x_new     = cmd.src_impulse ? first_reg : 1'b1;

    // tap terms
    assign b_term = AW'(b_mem[tap]) <<< 12;
    assign d_term = (prod_reg + (prod_reg[AW-1] ? AW'(255) : AW'(0))) >>> 8;

    // magnitudes for the divider
    assign acc_mag = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign n_wide  = {acc_mag, 8'b0};
    assign a0      = a_mem[0];
    assign a0_mag  = a0[VW-1] ? VW'(-a0) : VW'(a0);

    // one restoring division step
    assign r_shift = {rem_reg, nl_reg[VW-1]};
    assign r_ge    = (r_shift >= {1'b0, dmag_reg});

    // output value and saturation
    always_comb
    begin
        y_val = $signed(quo_reg);
        y_sat = 1'b0;
        if (err_reg)
        begin
            y_val = accneg_reg ? $signed(iir_sir_pkg::SAMPLE_MIN)
                               : $signed(iir_sir_pkg::SAMPLE_MAX);
            y_sat = 1'b1;
        end
        else if (ovf_reg)
        begin
            y_val = neg_reg ? $signed(iir_sir_pkg::SAMPLE_MIN)
                            : $signed(iir_sir_pkg::SAMPLE_MAX);
            y_sat = 1'b1;
        end
        else if (neg_reg)
        begin
            if (quo_reg > iir_sir_pkg::SAMPLE_MIN)
            begin
                y_val = $signed(iir_sir_pkg::SAMPLE_MIN);
                y_sat = 1'b1;
            end
            else
            begin
                y_val = $signed(VW'(-quo_reg));
            end
        end
        else if (quo_reg > iir_sir_pkg::SAMPLE_MAX)
        begin
            y_val = $signed(iir_sir_pkg::SAMPLE_MAX);
            y_sat = 1'b1;
        end
    end

    assign status.skip_div = err_reg || ovf_reg;
    assign status.out_free = !out_valid || out_ready;

    // coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                b_mem[k] <= '0;
                a_mem[k] <= '0;
            end
        end
        else
        begin
            if (cmd.load_b && idx_ok)
            begin
                b_mem[load_idx] <= coeff_ext;
            end
            if (cmd.load_a && idx_ok)
            begin
                a_mem[load_idx] <= coeff_ext;
            end
        end
    end

    // histories, sample counter, first-sample flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                xh_reg[k] <= 1'b0;
                yh_reg[k] <= '0;
            end
            count_reg <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.restart)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                xh_reg[k] <= 1'b0;
                yh_reg[k] <= '0;
            end
            count_reg <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cmd.start)
            begin
                xh_reg[0] <= x_new;
                for (int k = 1; k < DEPTH; k++)
                begin
                    xh_reg[k] <= xh_reg[k-1];
                end
            end
            if (cmd.finish)
            begin
                yh_reg[0] <= y_val;
                for (int k = 1; k < DEPTH; k++)
                begin
                    yh_reg[k] <= yh_reg[k-1];
                end
                count_reg <= count_reg + 1'b1;
                first_reg <= 1'b0;
            end
        end
    end

    // multiply-accumulate and divider
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (cmd.num_step)
        begin
            if (xh_reg[tap])
            begin
                acc_reg <= acc_reg + b_term;
            end
        end
        else if (cmd.den_acc)
        begin
            acc_reg <= acc_reg - d_term;
        end
        if (cmd.den_issue)
        begin
            prod_reg <= a_mem[tap] * yh_reg[tap - IDX_W'(1)];
        end
        if (cmd.div_prep)
        begin
            err_reg    <= (a0 == '0);
            ovf_reg    <= (n_wide[AW+7:VW] >= (AW+8-VW)'(a0_mag));
            neg_reg    <= acc_reg[AW-1] ^ a0[VW-1];
            accneg_reg <= acc_reg[AW-1];
            rem_reg    <= n_wide[2*VW-1:VW];
            nl_reg     <= n_wide[VW-1:0];
            dmag_reg   <= a0_mag;
            quo_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r_ge ? VW'(r_shift - {1'b0, dmag_reg}) : r_shift[VW-1:0];
            quo_reg <= {quo_reg[VW-2:0], r_ge};
            nl_reg  <= {nl_reg[VW-2:0], 1'b0};
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_sample <= y_val;
            out_index  <= count_reg;
            out_err    <= err_reg;
            out_sat    <= y_sat;
        end
    end

endmodule

`default_nettype wire

@@ design/iir_step_impulse_response.sv @@
// top level of the direct-form I step and impulse response filter
//
// request channel: one word carries a command. loads of b[k] or a[k] and a
// restart take effect in the cycle they are accepted and give no result. a
// next-sample word starts a run of the shared multiply-accumulate over the
// numerator taps, then the denominator taps and a drain of the multiplier
// (both skipped when D is zero), one setup step and a restoring divider by
// a0, then a store of the result. when a0 is zero or the quotient overflows
// the division steps are skipped.
// one sample is in work at a time; ready on the request channel is low
// during a run. configuration words (degrees, source mode) are always taken.
// the response word sits in an output register: the next request is taken
// while it waits, and a run holds in its last cycle while the receiver
// stalls with the register full.
// reset clears coefficients, histories, sample counter and configuration.
`default_nettype none

module iir_step_impulse_response #(
    parameter int MAX_DEGREE  = 15,
    parameter int COEFF_WIDTH = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    iir_req_if.sink    request,
    iir_rsp_if.source  response,
    iir_cfg_if.sink    cfg
);

    `include "iir_step_impulse_response_defines.svh"

    localparam int IDX_W = (MAX_DEGREE < 1) ? 1 : $clog2(MAX_DEGREE + 1);

    iir_sir_pkg::dp_cmd_t    cmd;
    iir_sir_pkg::dp_status_t status;
    logic [IDX_W-1:0]        tap;

    // controller
    iir_sir_ctrl #(
        .MAX_DEGREE (MAX_DEGREE),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (request.ready),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cfg_ready   (cfg.ready),
        .status      (status),
        .cmd         (cmd),
        .tap         (tap)
    );

    // datapath
    iir_sir_dp #(
        .MAX_DEGREE  (MAX_DEGREE),
        .COEFF_WIDTH (COEFF_WIDTH),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .tap         (tap),
        .status      (status),
        .coeff_index (request.coeff_index),
        .coeff_value (request.coeff_value),
        .out_ready   (response.ready),
        .out_valid   (response.valid),
        .out_sample  (response.response_sample),
        .out_index   (response.sample_index),
        .out_err     (response.divide_error),
        .out_sat     (response.saturated)
    );

    // a divide error always reports saturation
    `IIR_ASSERT_SAME(a_err_sat, response.valid && response.divide_error, response.saturated)

    // a clipped sample is at one of the rails
    `IIR_ASSERT_SAME(a_sat_rail, response.valid && response.saturated,
        (response.response_sample == $signed(iir_sir_pkg::SAMPLE_MAX)) ||
        (response.response_sample == $signed(iir_sir_pkg::SAMPLE_MIN)))

    // an accepted sample request starts a run that blocks the next request
    `IIR_ASSERT_NEXT(a_run_busy,
        request.valid && request.ready && (request.command == iir_sir_pkg::CMD_SAMPLE),
        !request.ready)

endmodule

`default_nettype wire
